@@ sv/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define URBI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("urbi check failed");

// next-cycle implication, disabled during reset
`define URBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("urbi check failed");

`endif

@@ sv/urbi_pkg.sv @@
// shared types and constants for the uart ring buffer interface
// no dependencies
package urbi_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int WORD_W        = 9;
   localparam int CNT_W         = 16;
   localparam int NUM_ERR       = 4;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // transaction kinds
   localparam logic [1:0] MODE_PUSH    = 2'd0;
   localparam logic [1:0] MODE_POP     = 2'd1;
   localparam logic [1:0] MODE_SERVICE = 2'd2;

   // error counter slots
   localparam int ERR_PARITY  = 0;
   localparam int ERR_FRAMING = 1;
   localparam int ERR_NOISE   = 2;
   localparam int ERR_OVERRUN = 3;

   typedef struct packed {
      logic [1:0]        mode;
      logic [WORD_W-1:0] data_in;
      logic              parity_error;
      logic              framing_error;
      logic              noise_error;
      logic              overrun_error;
      logic              rx_ready;
      logic              tx_empty;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [WORD_W-1:0] data_out;
      logic              send_valid;
      logic              tx_irq_enabled;
      logic              tx_full;
      logic              rx_full;
      logic              tx_overflowed;
      logic              rx_overflowed;
      logic [CNT_W-1:0]  parity_count;
      logic [CNT_W-1:0]  framing_count;
      logic [CNT_W-1:0]  noise_count;
      logic [CNT_W-1:0]  overrun_count;
   } rsp_type;

   // requests into one ring
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [WORD_W-1:0] word;
   } ring_ctrl_type;

   // status out of one ring, from the current pointers and the sticky overflow flag
   typedef struct packed {
      logic full;
      logic empty;
      logic lost;
   } ring_stat_type;

endpackage

@@ sv/urbi_ring.sv @@
// one ring fifo: word memory with registered read, head/tail pointers, sticky overflow
// depends on urbi_pkg
module urbi_ring #(
   parameter int DEPTH = urbi_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  urbi_pkg::ring_ctrl_type       ctrl,
   output urbi_pkg::ring_stat_type       stat,
   output logic [urbi_pkg::WORD_W-1:0]   rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [urbi_pkg::WORD_W-1:0] mem [DEPTH];
   logic [urbi_pkg::WORD_W-1:0] rd_ff;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [PTR_W-1:0]            tail_ff, tail_in;
   logic                        lost_ff, lost_in;
   logic                        full, empty, push_ok, pop_ok;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // one slot stays empty to tell full from empty
   always_comb begin
      full    = (next_ptr(head_ff) == tail_ff);
      empty   = (head_ff == tail_ff);
      push_ok = ctrl.push & ~full;
      pop_ok  = ctrl.pop & ~empty;
      head_in = push_ok ? next_ptr(head_ff) : head_ff;
      tail_in = pop_ok ? next_ptr(tail_ff) : tail_ff;
      lost_in = lost_ff | (ctrl.push & full);
   end

   // pointer and flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         lost_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         lost_ff <= lost_in;
      end
   end

   // word memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[head_ff] <= ctrl.word;
      end
      if (pop_ok) begin
         rd_ff <= mem[tail_ff];
      end
   end

   assign stat.full  = full;
   assign stat.empty = empty;
   assign stat.lost  = lost_ff;
   assign rd_data    = rd_ff;

endmodule

@@ sv/uart_ring_buffer_interface_top.sv @@
// top level of the uart ring buffer interface: transmit and receive rings, error counters
// depends on urbi_pkg and urbi_ring
// the result of a transaction shows on rsp_valid in the cycle after it is accepted
// throughput: one transaction per cycle while busy is low; each ring memory does at most one read and one write
// per transaction, the popped word comes from the ring's registered read port
// reset: synchronous; busy is set by reset and cleared on any clock without reset; rings, flags and counters
// clear, ring memories are not cleared; results cannot be stalled by the receiver
module uart_ring_buffer_interface_top #(
   parameter int DEPTH = urbi_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  urbi_pkg::req_type req_data,
   output logic              rsp_valid,
   output urbi_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   urbi_pkg::ring_ctrl_type     tx_ctrl, rx_ctrl;
   urbi_pkg::ring_stat_type     tx_stat, rx_stat;
   logic [urbi_pkg::WORD_W-1:0] tx_rd, rx_rd;

   logic                        busy_ff;
   logic                        nine_ff;
   logic                        irq_ff, irq_in;
   logic                        valid_ff, valid_in;
   logic                        accepted_ff, accepted_in;
   logic                        send_ff, send_in;
   logic                        rx_pop_ff, rx_pop_in;
   logic [urbi_pkg::CNT_W-1:0]  cnt_ff [urbi_pkg::NUM_ERR];
   logic [urbi_pkg::CNT_W-1:0]  cnt_in [urbi_pkg::NUM_ERR];

   logic                        take;
   logic                        any_err;
   logic [urbi_pkg::NUM_ERR-1:0] err_bits;
   logic [urbi_pkg::WORD_W-1:0] word;

   urbi_ring #(.DEPTH(DEPTH)) u_tx_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (tx_ctrl),
      .stat    (tx_stat),
      .rd_data (tx_rd)
   );

   urbi_ring #(.DEPTH(DEPTH)) u_rx_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (rx_ctrl),
      .stat    (rx_stat),
      .rd_data (rx_rd)
   );

   // transaction decode into ring requests
   always_comb begin
      take     = start & ~busy_ff;
      err_bits = {req_data.overrun_error, req_data.noise_error,
                  req_data.framing_error, req_data.parity_error};
      any_err  = |err_bits;
      word     = nine_ff ? req_data.data_in : {1'b0, req_data.data_in[7:0]};

      tx_ctrl.word = word;
      tx_ctrl.push = take & (req_data.mode == urbi_pkg::MODE_PUSH);
      tx_ctrl.pop  = take & (req_data.mode == urbi_pkg::MODE_SERVICE)
                     & req_data.tx_empty & irq_ff;

      rx_ctrl.word = word;
      rx_ctrl.push = take & (req_data.mode == urbi_pkg::MODE_SERVICE)
                     & ~any_err & req_data.rx_ready;
      rx_ctrl.pop  = take & (req_data.mode == urbi_pkg::MODE_POP);
   end

   // result flags and transmit interrupt enable
   always_comb begin
      valid_in    = take;
      send_in     = tx_ctrl.pop & ~tx_stat.empty;
      rx_pop_in   = rx_ctrl.pop & ~rx_stat.empty;
      accepted_in = (tx_ctrl.push & ~tx_stat.full) | (rx_ctrl.push & ~rx_stat.full)
                    | rx_pop_in;
      irq_in = irq_ff;
      if (tx_ctrl.push & ~tx_stat.full) begin
         irq_in = 1'b1;
      end else if (tx_ctrl.pop & tx_stat.empty) begin
         irq_in = 1'b0;
      end
   end

   // saturating error counters
   always_comb begin
      for (int k = 0; k < urbi_pkg::NUM_ERR; k++) begin
         cnt_in[k] = cnt_ff[k];
         if (take && (req_data.mode == urbi_pkg::MODE_SERVICE) && err_bits[k]
             && (cnt_ff[k] != urbi_pkg::CNT_MAX)) begin
            cnt_in[k] = cnt_ff[k] + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         nine_ff     <= 1'b0;
         irq_ff      <= 1'b0;
         valid_ff    <= 1'b0;
         accepted_ff <= 1'b0;
         send_ff     <= 1'b0;
         rx_pop_ff   <= 1'b0;
         for (int k = 0; k < urbi_pkg::NUM_ERR; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         busy_ff     <= 1'b0;
         if (csr_we) begin
            nine_ff <= csr_wdata;
         end
         irq_ff      <= irq_in;
         valid_ff    <= valid_in;
         accepted_ff <= accepted_in;
         send_ff     <= send_in;
         rx_pop_ff   <= rx_pop_in;
         for (int k = 0; k < urbi_pkg::NUM_ERR; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   // result transaction, status taken from the updated state
   always_comb begin
      rsp_data.accepted       = accepted_ff;
      rsp_data.data_out       = send_ff ? tx_rd : (rx_pop_ff ? rx_rd : '0);
      rsp_data.send_valid     = send_ff;
      rsp_data.tx_irq_enabled = irq_ff;
      rsp_data.tx_full        = tx_stat.full;
      rsp_data.rx_full        = rx_stat.full;
      rsp_data.tx_overflowed  = tx_stat.lost;
      rsp_data.rx_overflowed  = rx_stat.lost;
      rsp_data.parity_count   = cnt_ff[urbi_pkg::ERR_PARITY];
      rsp_data.framing_count  = cnt_ff[urbi_pkg::ERR_FRAMING];
      rsp_data.noise_count    = cnt_ff[urbi_pkg::ERR_NOISE];
      rsp_data.overrun_count  = cnt_ff[urbi_pkg::ERR_OVERRUN];
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

@@ sv/urbi_checker.sv @@
// port-level checks for the uart ring buffer interface, bound to the top level
// depends on urbi_pkg, assert_macros.svh and uart_ring_buffer_interface_top
`include "assert_macros.svh"

module urbi_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input urbi_pkg::rsp_type rsp_data
);

   // every accepted transaction gives exactly one result in the next cycle
   `URBI_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, rsp_valid)
   `URBI_ASSERT_NEXT(a_no_stray_rsp, clock, reset, !(start && !busy), !rsp_valid)

   // a word handed to the transmitter means the interrupt stayed enabled
   `URBI_ASSERT_NOW(a_send_irq, clock, reset, rsp_valid && rsp_data.send_valid,
                    rsp_data.tx_irq_enabled)

   // data_out is zero unless a word was popped
   `URBI_ASSERT_NOW(a_data_zero, clock, reset,
                    rsp_valid && !rsp_data.send_valid && !rsp_data.accepted,
                    rsp_data.data_out == '0)

endmodule

bind uart_ring_buffer_interface_top urbi_checker u_checker (.*);

@@ test/uart_ring_buffer_interface_top_test.sv @@
// self-checking testbench for uart_ring_buffer_interface_top: random and directed transactions
// checked against a cycle-free model of both rings and the error counters
// depends on urbi_pkg and the uart_ring_buffer_interface_top rtl
`timescale 1ns / 100ps

module uart_ring_buffer_interface_top_test;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RING_SLOTS = urbi_pkg::DEPTH_DEFAULT - 1;

   typedef enum {SEG_MIXED, SEG_FILL_TX, SEG_FILL_RX, SEG_DRAIN} seg_kind_type;

   // model of both rings, the irq enable and the counters, plus the expected responses
   class uart_ring_scoreboard;
      logic                 nine_bit;
      logic [8:0]           tx_words[$];
      logic [8:0]           rx_words[$];
      logic                 tx_lost;
      logic                 rx_lost;
      logic                 irq_on;
      logic [15:0]          err_cnt[urbi_pkg::NUM_ERR];
      urbi_pkg::rsp_type    expected_rsp[$];
      int                   failures;

      function new();
         nine_bit = 1'b0;
         tx_lost  = 1'b0;
         rx_lost  = 1'b0;
         irq_on   = 1'b0;
         failures = 0;
         foreach (err_cnt[k]) err_cnt[k] = '0;
      endfunction

      function void bump(int k);
         if (err_cnt[k] != urbi_pkg::CNT_MAX) err_cnt[k] = err_cnt[k] + 16'd1;
      endfunction

      // work out the response of one accepted transaction
      function void note_request(urbi_pkg::req_type r);
         urbi_pkg::rsp_type e;
         logic [8:0]        mask;
         e = '0;
         mask = nine_bit ? 9'h1FF : 9'h0FF;
         case (r.mode)
            urbi_pkg::MODE_PUSH: begin
               if (tx_words.size() < RING_SLOTS) begin
                  tx_words.push_back(r.data_in & mask);
                  e.accepted = 1'b1;
                  irq_on = 1'b1;
               end else begin
                  tx_lost = 1'b1;
               end
            end
            urbi_pkg::MODE_POP: begin
               if (rx_words.size() != 0) begin
                  e.accepted = 1'b1;
                  e.data_out = rx_words.pop_front();
               end
            end
            urbi_pkg::MODE_SERVICE: begin
               // errors are counted and drop the received word, otherwise a ready word is stored
               if (r.parity_error || r.framing_error || r.noise_error || r.overrun_error) begin
                  if (r.parity_error) bump(urbi_pkg::ERR_PARITY);
                  if (r.framing_error) bump(urbi_pkg::ERR_FRAMING);
                  if (r.noise_error) bump(urbi_pkg::ERR_NOISE);
                  if (r.overrun_error) bump(urbi_pkg::ERR_OVERRUN);
               end else if (r.rx_ready) begin
                  if (rx_words.size() < RING_SLOTS) begin
                     rx_words.push_back(r.data_in & mask);
                     e.accepted = 1'b1;
                  end else begin
                     rx_lost = 1'b1;
                  end
               end
               // transmit side
               if (r.tx_empty && irq_on) begin
                  if (tx_words.size() != 0) begin
                     e.data_out = tx_words.pop_front();
                     e.send_valid = 1'b1;
                  end else begin
                     irq_on = 1'b0;
                  end
               end
            end
            default: ;
         endcase
         e.tx_irq_enabled = irq_on;
         e.tx_full        = (tx_words.size() == RING_SLOTS);
         e.rx_full        = (rx_words.size() == RING_SLOTS);
         e.tx_overflowed  = tx_lost;
         e.rx_overflowed  = rx_lost;
         e.parity_count   = err_cnt[urbi_pkg::ERR_PARITY];
         e.framing_count  = err_cnt[urbi_pkg::ERR_FRAMING];
         e.noise_count    = err_cnt[urbi_pkg::ERR_NOISE];
         e.overrun_count  = err_cnt[urbi_pkg::ERR_OVERRUN];
         expected_rsp.push_back(e);
      endfunction

      function void cmp(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(urbi_pkg::rsp_type got);
         urbi_pkg::rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("response transaction with nothing expected");
            failures++;
            return;
         end
         want = expected_rsp.pop_front();
         cmp("accepted", want.accepted, got.accepted);
         cmp("data_out", want.data_out, got.data_out);
         cmp("send_valid", want.send_valid, got.send_valid);
         cmp("tx_irq_enabled", want.tx_irq_enabled, got.tx_irq_enabled);
         cmp("tx_full", want.tx_full, got.tx_full);
         cmp("rx_full", want.rx_full, got.rx_full);
         cmp("tx_overflowed", want.tx_overflowed, got.tx_overflowed);
         cmp("rx_overflowed", want.rx_overflowed, got.rx_overflowed);
         cmp("parity_count", want.parity_count, got.parity_count);
         cmp("framing_count", want.framing_count, got.framing_count);
         cmp("noise_count", want.noise_count, got.noise_count);
         cmp("overrun_count", want.overrun_count, got.overrun_count);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   urbi_pkg::req_type req_data;
   logic              rsp_valid;
   urbi_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic              csr_wdata;

   uart_ring_scoreboard board = new();

   uart_ring_buffer_interface_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_response(rsp_data);
   end

   function automatic urbi_pkg::req_type mk(logic [1:0] mode, logic [8:0] data, logic pe,
                                            logic fe, logic ne, logic oe, logic rxr,
                                            logic txe);
      urbi_pkg::req_type r;
      r.mode          = mode;
      r.data_in       = data;
      r.parity_error  = pe;
      r.framing_error = fe;
      r.noise_error   = ne;
      r.overrun_error = oe;
      r.rx_ready      = rxr;
      r.tx_empty      = txe;
      return r;
   endfunction

   // random transaction shaped by the kind of segment it belongs to
   function automatic urbi_pkg::req_type rand_item(seg_kind_type k);
      int                pick;
      urbi_pkg::req_type r;
      pick = $urandom_range(99);
      r = mk(urbi_pkg::MODE_SERVICE, 9'($urandom_range(511)), $urandom_range(7) == 0,
             $urandom_range(7) == 0, $urandom_range(7) == 0, $urandom_range(7) == 0,
             1'($urandom_range(1)), 1'($urandom_range(1)));
      case (k)
         SEG_FILL_TX: begin
            if (pick < 90) r.mode = urbi_pkg::MODE_PUSH;
            else r.tx_empty = 1'b0;
         end
         SEG_FILL_RX: begin
            if (pick < 90) begin
               {r.parity_error, r.framing_error, r.noise_error, r.overrun_error} = '0;
               r.rx_ready = 1'b1;
               r.tx_empty = 1'b0;
            end else begin
               r.mode = urbi_pkg::MODE_PUSH;
            end
         end
         SEG_DRAIN: begin
            if (pick < 50) r.mode = urbi_pkg::MODE_POP;
            else r.tx_empty = 1'b1;
         end
         default: begin
            if (pick < 3) r.mode = MODE_UNUSED;
            else if (pick < 33) r.mode = urbi_pkg::MODE_PUSH;
            else if (pick < 58) r.mode = urbi_pkg::MODE_POP;
         end
      endcase
      return r;
   endfunction

   // one transaction, then an optional random idle stretch
   task automatic send_request(input urbi_pkg::req_type r, input int idle_pct);
      if (!start) start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.note_request(r);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (board.expected_rsp.size() != 0);
   endtask

   task automatic write_word_len(input logic nine);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= nine;
      @(posedge clock);
      board.nine_bit = nine;
      csr_we <= 1'b0;
   endtask

   // segments of fill, drain and mixed traffic
   task automatic run_random(input int idle_pct, input int n_items);
      int           sent;
      int           len;
      seg_kind_type k;
      sent = 0;
      while (sent < n_items) begin
         k = seg_kind_type'($urandom_range(3));
         len = (k == SEG_FILL_TX || k == SEG_FILL_RX) ? 70 :
               (k == SEG_DRAIN) ? $urandom_range(80, 30) : $urandom_range(40, 20);
         repeat (len) send_request(rand_item(k), idle_pct);
         sent += len;
         if ($urandom_range(3) == 0) wait_drained();
      end
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: unused mode, empty pops, masking, errors, word-length change
      send_request(mk(MODE_UNUSED, 9'h1FF, 1, 1, 1, 1, 1, 1), 34);
      send_request(mk(urbi_pkg::MODE_POP, 9'h1FF, 0, 0, 0, 0, 0, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h000, 0, 0, 0, 0, 0, 1), 34);
      send_request(mk(urbi_pkg::MODE_PUSH, 9'h1FF, 0, 0, 0, 0, 0, 0), 34);
      send_request(mk(urbi_pkg::MODE_PUSH, 9'h000, 0, 0, 0, 0, 0, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h1FF, 0, 0, 0, 0, 1, 1), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h155, 1, 1, 1, 1, 1, 1), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h000, 0, 0, 0, 0, 0, 1), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h0AA, 1, 0, 0, 0, 1, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h0AA, 0, 1, 0, 0, 1, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h0AA, 0, 0, 1, 0, 1, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h0AA, 0, 0, 0, 1, 1, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h0AA, 0, 0, 0, 0, 0, 0), 34);
      send_request(mk(urbi_pkg::MODE_POP, 9'h000, 0, 0, 0, 0, 0, 0), 34);
      send_request(mk(urbi_pkg::MODE_POP, 9'h000, 0, 0, 0, 0, 0, 0), 34);
      write_word_len(1'b1);
      send_request(mk(urbi_pkg::MODE_PUSH, 9'h1AA, 0, 0, 0, 0, 0, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h1C3, 0, 0, 0, 0, 1, 0), 34);
      write_word_len(1'b0);
      send_request(mk(urbi_pkg::MODE_POP, 9'h000, 0, 0, 0, 0, 0, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h000, 0, 0, 0, 0, 0, 1), 34);
      send_request(mk(urbi_pkg::MODE_PUSH, 9'h100, 0, 0, 0, 0, 0, 0), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h000, 0, 0, 0, 0, 0, 1), 34);
      send_request(mk(urbi_pkg::MODE_SERVICE, 9'h000, 0, 0, 0, 0, 0, 1), 34);

      // random phases with different idle rates and word lengths
      write_word_len(1'b1);
      run_random(34, 100);
      write_word_len(1'b0);
      run_random(84, 100);
      write_word_len(1'($urandom_range(1)));
      run_random(0, 100);

      wait_drained();
      repeat (4) @(posedge clock);
      if (board.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
